[design/afdc_pkg.sv]
// shared types and constants for the api frame deframer with checksum
package afdc_pkg;

    localparam logic [7:0]  START_BYTE      = 8'h7E;
    localparam logic [7:0]  SUM_BASE        = 8'hFF;
    localparam logic [15:0] MAX_LEN_DEFAULT = 16'd124;

    typedef enum logic [1:0] {
        PH_HUNT   = 2'd0,
        PH_LEN_HI = 2'd1,
        PH_LEN_LO = 2'd2,
        PH_BODY   = 2'd3
    } phase_t;

    typedef struct packed {
        logic [7:0] frame_byte;
        logic       first_of_frame;
        logic       last_of_frame;
        logic       frame_good;
        logic       previous_aborted;
    } result_t;

endpackage

[design/afdc_if.sv]
// valid/ready stream interfaces for received bytes and frame bytes
interface afdc_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

interface afdc_frame_if;
    logic       valid;
    logic       ready;
    logic [7:0] frame_byte;
    logic       first_of_frame;
    logic       last_of_frame;
    logic       frame_good;
    logic       previous_aborted;

    modport source (
        output valid, output frame_byte, output first_of_frame, output last_of_frame,
        output frame_good, output previous_aborted, input ready
    );
    modport sink (
        input valid, input frame_byte, input first_of_frame, input last_of_frame,
        input frame_good, input previous_aborted, output ready
    );
endinterface

[design/api_frame_deframer_checksum_core.sv]
// top level of the api frame deframer: input register, framer, result register
// a received byte is held in the input register, then its frame byte in the result register
// throughput: one byte per cycle while no stall holds the input register; the framer state updates once per byte
// a stall on the result side holds an input byte that has a result, and the input register then drops ready
// reset: asynchronous active low; framer hunts for the start byte, max length is 124
// bytes other than the start byte seen while hunting produce no request on the frame stream
module api_frame_deframer_checksum_core
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cfg_write_en,
    input  logic [15:0]   cfg_write_data,
    afdc_byte_if.sink     byte_stream,
    afdc_frame_if.source  frame_stream
);
    import afdc_pkg::*;

    logic        in_valid_reg;
    logic [7:0]  in_byte_reg;
    logic [15:0] max_body_length_reg;
    logic        emit;
    logic        out_free;
    logic        advance;
    result_t     result;

    // a byte with no result leaves even while the output is stalled
    assign advance = in_valid_reg && (!emit || out_free);
    assign byte_stream.ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg        <= 1'b0;
            max_body_length_reg <= MAX_LEN_DEFAULT;
        end
        else
        begin
            if (byte_stream.ready)
            begin
                in_valid_reg <= byte_stream.valid;
            end
            if (cfg_write_en)
            begin
                max_body_length_reg <= cfg_write_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (byte_stream.ready && byte_stream.valid)
        begin
            in_byte_reg <= byte_stream.rx_byte;
        end
    end

    afdc_framer u_framer
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .advance         (advance),
        .rx_byte         (in_byte_reg),
        .max_body_length (max_body_length_reg),
        .emit            (emit),
        .result          (result)
    );

    afdc_out_stage u_out_stage
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .load         (advance && emit),
        .result       (result),
        .free         (out_free),
        .frame_stream (frame_stream)
    );

    a_good_needs_last: assert property (@(posedge clk) disable iff (!rst_n)
        frame_stream.valid && frame_stream.frame_good |-> frame_stream.last_of_frame)
        else $error("frame_good without last_of_frame");

    a_abort_on_first: assert property (@(posedge clk) disable iff (!rst_n)
        frame_stream.valid && frame_stream.previous_aborted |-> frame_stream.first_of_frame)
        else $error("previous_aborted on a byte that is not a start byte");

    a_first_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        frame_stream.valid && frame_stream.first_of_frame |-> !frame_stream.last_of_frame)
        else $error("start byte marked as last of frame");

    a_held_byte_kept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !advance |=> in_valid_reg && $stable(in_byte_reg))
        else $error("stalled input byte lost");

endmodule

[design/afdc_framer.sv]
// framing state machine: length capture, body count, running sum and checksum test
module afdc_framer
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    advance,
    input  logic [7:0]              rx_byte,
    input  logic [15:0]             max_body_length,
    output logic                    emit,
    output afdc_pkg::result_t       result
);
    import afdc_pkg::*;

    phase_t      phase_reg, phase_next;
    logic [15:0] body_length_reg, body_length_next;
    logic [15:0] body_count_reg, body_count_next;
    logic [7:0]  running_sum_reg, running_sum_next;
    logic [15:0] full_length;

    assign full_length = {body_length_reg[15:8], rx_byte};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_HUNT;
            body_length_reg <= '0;
            body_count_reg  <= '0;
            running_sum_reg <= '0;
        end
        else if (advance)
        begin
            phase_reg       <= phase_next;
            body_length_reg <= body_length_next;
            body_count_reg  <= body_count_next;
            running_sum_reg <= running_sum_next;
        end
    end

    always_comb
    begin
        phase_next       = phase_reg;
        body_length_next = body_length_reg;
        body_count_next  = body_count_reg;
        running_sum_next = running_sum_reg;
        emit             = 1'b1;
        result           = '{frame_byte: rx_byte, default: 1'b0};

        if (rx_byte == START_BYTE)
        begin
            // a delimiter restarts framing in any phase
            phase_next              = PH_LEN_HI;
            body_length_next        = '0;
            body_count_next         = '0;
            running_sum_next        = '0;
            result.first_of_frame   = 1'b1;
            result.previous_aborted = (phase_reg != PH_HUNT);
        end
        else
        begin
            case (phase_reg)
                PH_HUNT:
                begin
                    emit = 1'b0;
                end
                PH_LEN_HI:
                begin
                    body_length_next = {rx_byte, 8'h00};
                    phase_next       = PH_LEN_LO;
                end
                PH_LEN_LO:
                begin
                    body_count_next  = '0;
                    running_sum_next = '0;
                    if (full_length > max_body_length)
                    begin
                        phase_next           = PH_HUNT;
                        body_length_next     = '0;
                        result.last_of_frame = 1'b1;
                    end
                    else
                    begin
                        phase_next       = PH_BODY;
                        body_length_next = full_length;
                    end
                end
                PH_BODY:
                begin
                    if (body_count_reg < body_length_reg)
                    begin
                        running_sum_next = running_sum_reg + rx_byte;
                        body_count_next  = body_count_reg + 16'd1;
                    end
                    else
                    begin
                        // checksum byte closes the frame
                        phase_next           = PH_HUNT;
                        body_length_next     = '0;
                        body_count_next      = '0;
                        running_sum_next     = '0;
                        result.last_of_frame = 1'b1;
                        result.frame_good    = (rx_byte == (SUM_BASE - running_sum_reg));
                    end
                end
                default:
                begin
                    emit = 1'b0;
                end
            endcase
        end
    end

endmodule

[design/afdc_out_stage.sv]
// result register driving the frame byte stream
module afdc_out_stage
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                load,
    input  afdc_pkg::result_t   result,
    output logic                free,
    afdc_frame_if.source        frame_stream
);
    import afdc_pkg::*;

    logic    valid_reg;
    result_t data_reg;

    assign free = !valid_reg || frame_stream.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (free)
        begin
            valid_reg <= load;
        end
    end

    always_ff @(posedge clk)
    begin
        if (free && load)
        begin
            data_reg <= result;
        end
    end

    assign frame_stream.valid            = valid_reg;
    assign frame_stream.frame_byte       = data_reg.frame_byte;
    assign frame_stream.first_of_frame   = data_reg.first_of_frame;
    assign frame_stream.last_of_frame    = data_reg.last_of_frame;
    assign frame_stream.frame_good       = data_reg.frame_good;
    assign frame_stream.previous_aborted = data_reg.previous_aborted;

endmodule
